/* design/upn_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the path normalizer core.
// Used by upn_ctrl, upn_dp and unix_path_normalizer_core; no dependencies.
package upn_pkg;

	localparam int MAX_LEN_DEF = 4096;

	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 24;
	localparam int CHAR_W   = 8;
	localparam int IDX_W    = 12;
	localparam int LEN_W    = 13;

	localparam logic [CHAR_W-1:0] SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] DOT   = 8'h2E;

	localparam logic ANSWER_STATUS = 1'b0;
	localparam logic ANSWER_READ   = 1'b1;
	localparam logic KIND_CHAR     = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DOT1,
		ST_DOT2,
		ST_CHAR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_FINAL,
		ST_READ
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CAPTURE,
		CMD_START,
		CMD_CLRLAC,
		CMD_DOT,
		CMD_OPEN,
		CMD_PUT_DOT,
		CMD_PUT_CHAR,
		CMD_DROP_BEGIN,
		CMD_SCAN_RD,
		CMD_SCAN_HIT,
		CMD_RD_ISSUE,
		CMD_LOAD_READ,
		CMD_LOAD_STATUS
	} cmd_t;

	typedef struct packed {
		logic       kind;
		logic       is_slash;
		logic       is_dot;
		logic       is_final;
		logic       first_seen;
		logic       err;
		logic [1:0] lac;
		logic       scan_more;
		logic       rd_slash;
		logic       out_free;
	} status_t;

endpackage

/* design/upn_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing state machine of the path normalizer core.
// Depends on upn_pkg; drives commands into upn_dp and reads its status.
module upn_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  upn_pkg::status_t st,
	output upn_pkg::cmd_t    cmd
);
	import upn_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = CMD_NONE;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd     = CMD_CAPTURE;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (st.kind != KIND_CHAR) begin
					cmd     = CMD_RD_ISSUE;
					state_d = ST_READ;
				end else if (!st.first_seen) begin
					cmd     = CMD_START;
					state_d = ST_FINAL;
				end else if (st.err) begin
					state_d = ST_FINAL;
				end else if (st.is_slash) begin
					if (st.lac == 2'd2) begin
						cmd     = CMD_DROP_BEGIN;
						state_d = ST_SCAN_RD;
					end else begin
						cmd     = CMD_CLRLAC;
						state_d = ST_FINAL;
					end
				end else if (st.lac < 2'd2 && st.is_dot) begin
					cmd     = CMD_DOT;
					state_d = ST_FINAL;
				end else if (st.lac != 2'd3) begin
					cmd     = CMD_OPEN;
					state_d = (st.lac == 2'd0) ? ST_CHAR : ST_DOT1;
				end else begin
					cmd     = CMD_PUT_CHAR;
					state_d = ST_FINAL;
				end
			end
			ST_DOT1: begin
				cmd     = CMD_PUT_DOT;
				state_d = (st.lac == 2'd2) ? ST_DOT2 : ST_CHAR;
			end
			ST_DOT2: begin
				cmd     = CMD_PUT_DOT;
				state_d = ST_CHAR;
			end
			ST_CHAR: begin
				cmd     = CMD_PUT_CHAR;
				state_d = ST_FINAL;
			end
			ST_SCAN_RD: begin
				if (st.scan_more) begin
					cmd     = CMD_SCAN_RD;
					state_d = ST_SCAN_CHK;
				end else begin
					state_d = ST_FINAL;
				end
			end
			ST_SCAN_CHK: begin
				if (st.rd_slash) begin
					cmd     = CMD_SCAN_HIT;
					state_d = ST_FINAL;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_FINAL: begin
				if (!st.is_final) begin
					state_d = ST_IDLE;
				end else if (!st.err && st.lac == 2'd2) begin
					cmd     = CMD_DROP_BEGIN;
					state_d = ST_SCAN_RD;
				end else if (st.out_free) begin
					cmd     = CMD_LOAD_STATUS;
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (st.out_free) begin
					cmd     = CMD_LOAD_READ;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* design/upn_dp.sv */
`timescale 1ns / 1ps
// Datapath of the path normalizer core: item registers, result store,
// path state and output register. Depends on upn_pkg; driven by upn_ctrl.
module upn_dp #(
	parameter int MAX_LEN = upn_pkg::MAX_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [upn_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                          s_tuser,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [upn_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                          m_tuser,
	input  upn_pkg::cmd_t                 cmd,
	output upn_pkg::status_t              st
);
	import upn_pkg::*;

	localparam int AW = $clog2(MAX_LEN);
	localparam int PW = AW + 1;
	localparam int XW = (PW > LEN_W) ? PW : LEN_W;
	localparam logic [PW-1:0] MAX_P = PW'(MAX_LEN);
	localparam logic [PW-1:0] ONE_P = PW'(1);

	logic [7:0] mem [MAX_LEN];

	logic [CHAR_W-1:0] char_q;
	logic [IDX_W-1:0]  idx_q;
	logic              kind_q;
	logic              final_q;
	logic [CHAR_W-1:0] rdata_q;

	logic [PW-1:0] wp_q;
	logic [PW-1:0] psp_q;
	logic [PW-1:0] j_q;
	logic [1:0]    lac_q;
	logic          err_q;
	logic          first_q;
	logic          out_valid_q;
	logic          out_kind_q;
	logic          out_ok_q;
	logic [LEN_W-1:0]  out_len_q;
	logic [CHAR_W-1:0] out_data_q;

	logic              wp_gt1;
	logic              fits;
	logic              put_req;
	logic [CHAR_W-1:0] put_byte;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [CHAR_W-1:0] mem_wd;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;
	logic [PW-1:0]     drop_wp;
	logic [PW-1:0]     j_dec;
	logic [XW-1:0]     idx_x;
	logic [XW-1:0]     len_x;
	logic              rd_ok;

	assign wp_gt1  = wp_q > ONE_P;
	assign fits    = wp_q < MAX_P;
	assign drop_wp = (psp_q == '0) ? ONE_P : psp_q;
	assign j_dec   = j_q - ONE_P;
	assign idx_x   = XW'(idx_q);
	assign len_x   = err_q ? '0 : XW'(wp_q);
	assign rd_ok   = (idx_x < len_x) && (idx_x < XW'(MAX_LEN));

	always_comb begin
		put_req  = 1'b0;
		put_byte = char_q;
		case (cmd)
			CMD_OPEN: begin
				put_req  = wp_gt1;
				put_byte = SLASH;
			end
			CMD_PUT_DOT: begin
				put_req  = 1'b1;
				put_byte = DOT;
			end
			CMD_PUT_CHAR: begin
				put_req  = 1'b1;
				put_byte = char_q;
			end
			default: begin
				put_req  = 1'b0;
			end
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = wp_q[AW-1:0];
		mem_wd = put_byte;
		if (cmd == CMD_START) begin
			mem_we = 1'b1;
			mem_wa = '0;
			mem_wd = SLASH;
		end else if (put_req && !err_q && fits) begin
			mem_we = 1'b1;
		end
		mem_re = (cmd == CMD_SCAN_RD) || (cmd == CMD_RD_ISSUE);
		mem_ra = (cmd == CMD_SCAN_RD) ? j_dec[AW-1:0] : idx_x[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_CAPTURE) begin
			char_q  <= s_tdata[CHAR_W-1:0];
			idx_q   <= s_tdata[CHAR_W+IDX_W-1:CHAR_W];
			kind_q  <= s_tuser;
			final_q <= s_tlast;
		end
		if (cmd == CMD_LOAD_STATUS) begin
			out_kind_q <= ANSWER_STATUS;
			out_ok_q   <= !err_q;
			out_len_q  <= len_x[LEN_W-1:0];
			out_data_q <= '0;
		end else if (cmd == CMD_LOAD_READ) begin
			out_kind_q <= ANSWER_READ;
			out_ok_q   <= !err_q;
			out_len_q  <= len_x[LEN_W-1:0];
			out_data_q <= rd_ok ? rdata_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			psp_q       <= '0;
			j_q         <= '0;
			lac_q       <= '0;
			err_q       <= 1'b0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (put_req && !err_q) begin
				if (fits) begin
					wp_q <= wp_q + ONE_P;
				end else begin
					err_q <= 1'b1;
				end
			end
			case (cmd)
				CMD_START: begin
					first_q <= 1'b1;
					wp_q    <= ONE_P;
					psp_q   <= '0;
					lac_q   <= '0;
					err_q   <= (char_q != SLASH);
				end
				CMD_CLRLAC: begin
					lac_q <= '0;
				end
				CMD_DOT: begin
					lac_q <= lac_q + 2'd1;
				end
				CMD_OPEN: begin
					if (wp_gt1) begin
						psp_q <= wp_q;
					end
				end
				CMD_PUT_CHAR: begin
					lac_q <= 2'd3;
				end
				CMD_DROP_BEGIN: begin
					lac_q <= '0;
					if (wp_gt1) begin
						wp_q  <= drop_wp;
						psp_q <= '0;
						j_q   <= drop_wp;
					end else begin
						j_q   <= wp_q;
					end
				end
				CMD_SCAN_RD: begin
					j_q <= j_dec;
				end
				CMD_SCAN_HIT: begin
					psp_q <= j_q;
				end
				CMD_LOAD_STATUS: begin
					first_q <= 1'b0;
					lac_q   <= '0;
				end
				default: begin
				end
			endcase
			if (cmd == CMD_LOAD_STATUS || cmd == CMD_LOAD_READ) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st.kind       = kind_q;
		st.is_slash   = (char_q == SLASH);
		st.is_dot     = (char_q == DOT);
		st.is_final   = final_q;
		st.first_seen = first_q;
		st.err        = err_q;
		st.lac        = lac_q;
		st.scan_more  = j_q > ONE_P;
		st.rd_slash   = (rdata_q == SLASH);
		st.out_free   = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = M_DATA_W'({out_data_q, out_len_q, out_ok_q});

endmodule

/* design/unix_path_normalizer_core.sv */
`timescale 1ns / 1ps
// Top level of the path normalizer: joins upn_ctrl and upn_dp.
// Depends on upn_pkg, upn_ctrl and upn_dp.
//
// An absolute path enters one byte per word (tuser 0), tlast on its last
// byte; that byte returns a status word with ok and the normalized length,
// after which tuser 1 words read single bytes of the result. The block
// works on one word at a time: a path byte passes through accept, decode
// with any separator write, a state for each held dot and one for the byte
// when a component opens, and a closing state; a read passes through
// accept, a registered read of the result store and the output load. A
// ".." that removes a component adds a read and a check state for each
// stored byte scanned back to the previous separator, a further read state
// when the scan reaches the root, and a further closing pass when the ".."
// ends the path. The result store has MAX_LEN bytes and needs no clearing
// after reset; the output register lets a new word in while a result waits.
module unix_path_normalizer_core #(
	parameter int MAX_LEN = upn_pkg::MAX_LEN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [upn_pkg::S_DATA_W-1:0] s_tdata,  // path_char[7:0], read_index[19:8]
	input  logic                         s_tuser,  // kind
	input  logic                         s_tlast,  // is_final
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [upn_pkg::M_DATA_W-1:0] m_tdata,  // ok[0], result_length[13:1], read_data[21:14]
	output logic                         m_tuser   // answer_kind
);
	import upn_pkg::*;

	cmd_t    cmd;
	status_t st;

	upn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	upn_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.st       (st)
	);

	a_no_load_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !(cmd == CMD_LOAD_STATUS || cmd == CMD_LOAD_READ))
		else $error("output overwritten while stalled");

	a_result_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd == CMD_LOAD_STATUS || cmd == CMD_LOAD_READ))
		else $error("result word without a load");

	a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("new word accepted during work");

	a_scan_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_SCAN_RD) |-> st.scan_more)
		else $error("scan below first component");

endmodule
